>>> hdl/lsei_pkg.sv
package lsei_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int HALF_W      = COORD_WIDTH + 2;
	localparam int DIFF_W      = HALF_W + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int CROSS_W     = PROD_W + 1;
	localparam int N_CORNER    = 4;
	localparam int N_CROSS     = 12;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 4;

	typedef enum logic [1:0] {
		KIND_CIRCLE   = 2'd0,
		KIND_TRIANGLE = 2'd1,
		KIND_RECT     = 2'd2,
		KIND_OTHER    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_START_X = 2'd0,
		REG_START_Y = 2'd1,
		REG_END_X   = 2'd2,
		REG_END_Y   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ORI_COL = 2'd0,
		ORI_CW  = 2'd1,
		ORI_CCW = 2'd2
	} ori_t;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [HALF_W-1:0]      hcoord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [CROSS_W-1:0]     cross_t;

	// points in half units
	typedef struct packed {
		hcoord_t x;
		hcoord_t y;
	} point_t;

	typedef struct packed {
		point_t s;
		point_t e;
	} line_t;

	typedef struct packed {
		point_t a;
		point_t b;
		point_t c;
		point_t d;
		logic   is_rect;
	} corners_t;

	// cross product in quarter units truncates to zero inside (-4, 4)
	localparam cross_t CROSS_POS_MIN = CROSS_W'(4);
	localparam cross_t CROSS_NEG_MAX = -CROSS_POS_MIN;

endpackage

>>> hdl/lsei_shape_if.sv
interface lsei_shape_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          shape_kind;
	logic signed [lsei_pkg::COORD_WIDTH-1:0] centre_x;
	logic signed [lsei_pkg::COORD_WIDTH-1:0] centre_y;
	logic [lsei_pkg::COORD_WIDTH-1:0]    shape_width;
	logic [lsei_pkg::COORD_WIDTH-1:0]    shape_height;

	modport source (
		output valid, shape_kind, centre_x, centre_y, shape_width, shape_height,
		input  ready
	);
	modport sink (
		input  valid, shape_kind, centre_x, centre_y, shape_width, shape_height,
		output ready
	);
endinterface

>>> hdl/lsei_result_if.sv
interface lsei_result_if;
	logic valid;
	logic ready;
	logic crosses_line;

	modport source (output valid, crosses_line, input ready);
	modport sink (input valid, crosses_line, output ready);
endinterface

>>> hdl/lsei_cfg.sv
module lsei_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lsei_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [lsei_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [lsei_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output lsei_pkg::line_t                     line
);
	localparam int W = lsei_pkg::COORD_WIDTH;

	lsei_pkg::coord_t   start_x_q, start_y_q, end_x_q, end_y_q;
	lsei_pkg::coord_t   rd_val;
	lsei_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = lsei_pkg::reg_idx_t'(paddr[lsei_pkg::APB_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				lsei_pkg::REG_START_X: start_x_q <= pwdata[W-1:0];
				lsei_pkg::REG_START_Y: start_y_q <= pwdata[W-1:0];
				lsei_pkg::REG_END_X:   end_x_q   <= pwdata[W-1:0];
				lsei_pkg::REG_END_Y:   end_y_q   <= pwdata[W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			lsei_pkg::REG_START_X: rd_val = start_x_q;
			lsei_pkg::REG_START_Y: rd_val = start_y_q;
			lsei_pkg::REG_END_X:   rd_val = end_x_q;
			lsei_pkg::REG_END_Y:   rd_val = end_y_q;
		endcase
	end

	assign prdata = {{(lsei_pkg::APB_DATA_W-W){rd_val[W-1]}}, rd_val};

	// whole units to half units
	assign line.s.x = {{(lsei_pkg::HALF_W-W-1){start_x_q[W-1]}}, start_x_q, 1'b0};
	assign line.s.y = {{(lsei_pkg::HALF_W-W-1){start_y_q[W-1]}}, start_y_q, 1'b0};
	assign line.e.x = {{(lsei_pkg::HALF_W-W-1){end_x_q[W-1]}}, end_x_q, 1'b0};
	assign line.e.y = {{(lsei_pkg::HALF_W-W-1){end_y_q[W-1]}}, end_y_q, 1'b0};

endmodule

>>> hdl/lsei_geom.sv
module lsei_geom (
	input  logic               clk,
	input  logic               arst_n,
	lsei_shape_if.sink         shape,
	input  logic               ready_i,
	output logic               valid_o,
	output lsei_pkg::corners_t corners_o
);
	localparam int W  = lsei_pkg::COORD_WIDTH;
	localparam int HW = lsei_pkg::HALF_W;

	logic               v_s1, v_s2;
	logic               is_rect_s1;
	lsei_pkg::coord_t   cx_s1, cy_s1;
	logic [W-1:0]       w_s1, h_s1;
	lsei_pkg::corners_t corners_s2, corners_nx;
	logic               adv1, adv2, keep;
	lsei_pkg::hcoord_t  cx2, cy2, hw, hh, left, right, top, bot;

	assign adv2        = !v_s2 || ready_i;
	assign adv1        = !v_s1 || adv2;
	assign shape.ready = adv1;
	assign keep        = (shape.shape_kind == lsei_pkg::KIND_TRIANGLE) ||
	                     (shape.shape_kind == lsei_pkg::KIND_RECT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= shape.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && shape.valid) begin
			is_rect_s1 <= (shape.shape_kind == lsei_pkg::KIND_RECT);
			cx_s1      <= shape.centre_x;
			cy_s1      <= shape.centre_y;
			w_s1       <= shape.shape_width;
			h_s1       <= shape.shape_height;
		end
	end

	always_comb begin
		cx2   = {{(HW-W-1){cx_s1[W-1]}}, cx_s1, 1'b0};
		cy2   = {{(HW-W-1){cy_s1[W-1]}}, cy_s1, 1'b0};
		hw    = {{(HW-W){1'b0}}, w_s1};
		hh    = {{(HW-W){1'b0}}, h_s1};
		left  = cx2 - hw;
		right = cx2 + hw;
		top   = cy2 + hh;
		bot   = cy2 - hh;

		corners_nx.b.x     = left;
		corners_nx.b.y     = bot;
		corners_nx.c.x     = right;
		corners_nx.c.y     = bot;
		corners_nx.a.x     = is_rect_s1 ? left : cx2;
		corners_nx.a.y     = top;
		// triangle: fourth corner folds onto the apex, its edge is masked later
		corners_nx.d.x     = is_rect_s1 ? right : cx2;
		corners_nx.d.y     = top;
		corners_nx.is_rect = is_rect_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			corners_s2 <= corners_nx;
		end
	end

	assign valid_o   = v_s2;
	assign corners_o = corners_s2;

	a_drop_kind: assert property (@(posedge clk) disable iff (!arst_n)
		shape.valid && shape.ready && !keep |=> !v_s1)
		else $error("circle or other shape entered the pipeline");

	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ($signed(corners_s2.a.y) >= $signed(corners_s2.b.y)) &&
		         ($signed(corners_s2.c.x) >= $signed(corners_s2.b.x)))
		else $error("corner coordinate wrapped");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv2 |=> v_s2)
		else $error("shape lost between input and corner stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !ready_i |=> v_s2 && $stable(corners_s2))
		else $error("corner stage changed while stalled");

endmodule

>>> hdl/lsei_cross.sv
module lsei_cross (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_i,
	output logic               ready_o,
	input  lsei_pkg::corners_t corners_i,
	input  lsei_pkg::line_t    line,
	output logic               valid_o,
	input  logic               ready_i,
	output lsei_pkg::corners_t corners_o,
	output lsei_pkg::prod_t    m1_o [lsei_pkg::N_CROSS],
	output lsei_pkg::prod_t    m2_o [lsei_pkg::N_CROSS]
);
	localparam int NC = lsei_pkg::N_CROSS;

	lsei_pkg::point_t   tp [NC];
	lsei_pkg::point_t   tq [NC];
	lsei_pkg::point_t   tr [NC];
	lsei_pkg::point_t   ep [lsei_pkg::N_CORNER];
	lsei_pkg::point_t   eq [lsei_pkg::N_CORNER];
	lsei_pkg::diff_t    dqy [NC];
	lsei_pkg::diff_t    drx [NC];
	lsei_pkg::diff_t    dqx [NC];
	lsei_pkg::diff_t    dry [NC];
	lsei_pkg::prod_t    m1_s3 [NC];
	lsei_pkg::prod_t    m2_s3 [NC];
	lsei_pkg::corners_t corners_s3;
	logic               v_s3;

	assign ready_o = !v_s3 || ready_i;

	// edges a-b, b-c, c-d, d-a
	assign ep[0] = corners_i.a;
	assign eq[0] = corners_i.b;
	assign ep[1] = corners_i.b;
	assign eq[1] = corners_i.c;
	assign ep[2] = corners_i.c;
	assign eq[2] = corners_i.d;
	assign ep[3] = corners_i.d;
	assign eq[3] = corners_i.a;

	// 0..3: line against each corner; 4+2e, 5+2e: edge e against line ends
	always_comb begin
		for (int k = 0; k < lsei_pkg::N_CORNER; k++) begin
			tp[k]       = line.s;
			tq[k]       = line.e;
			tr[k]       = ep[k];
			tp[4+2*k]   = ep[k];
			tq[4+2*k]   = eq[k];
			tr[4+2*k]   = line.s;
			tp[5+2*k]   = ep[k];
			tq[5+2*k]   = eq[k];
			tr[5+2*k]   = line.e;
		end
	end

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			dqy[i] = $signed({tq[i].y[lsei_pkg::HALF_W-1], tq[i].y}) -
			         $signed({tp[i].y[lsei_pkg::HALF_W-1], tp[i].y});
			drx[i] = $signed({tr[i].x[lsei_pkg::HALF_W-1], tr[i].x}) -
			         $signed({tq[i].x[lsei_pkg::HALF_W-1], tq[i].x});
			dqx[i] = $signed({tq[i].x[lsei_pkg::HALF_W-1], tq[i].x}) -
			         $signed({tp[i].x[lsei_pkg::HALF_W-1], tp[i].x});
			dry[i] = $signed({tr[i].y[lsei_pkg::HALF_W-1], tr[i].y}) -
			         $signed({tq[i].y[lsei_pkg::HALF_W-1], tq[i].y});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_o) begin
			v_s3 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			corners_s3 <= corners_i;
			for (int i = 0; i < NC; i++) begin
				m1_s3[i] <= lsei_pkg::prod_t'(dqy[i]) * lsei_pkg::prod_t'(drx[i]);
				m2_s3[i] <= lsei_pkg::prod_t'(dqx[i]) * lsei_pkg::prod_t'(dry[i]);
			end
		end
	end

	assign valid_o   = v_s3;
	assign corners_o = corners_s3;
	assign m1_o      = m1_s3;
	assign m2_o      = m2_s3;

endmodule

>>> hdl/lsei_decide.sv
module lsei_decide (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_i,
	output logic               ready_o,
	input  lsei_pkg::corners_t corners_i,
	input  lsei_pkg::line_t    line,
	input  lsei_pkg::prod_t    m1_i [lsei_pkg::N_CROSS],
	input  lsei_pkg::prod_t    m2_i [lsei_pkg::N_CROSS],
	lsei_result_if.source      result
);
	localparam int NC = lsei_pkg::N_CROSS;
	localparam int NK = lsei_pkg::N_CORNER;

	function automatic lsei_pkg::ori_t orient(input lsei_pkg::cross_t c);
		lsei_pkg::ori_t o;
		if (c >= lsei_pkg::CROSS_POS_MIN)
			o = lsei_pkg::ORI_CW;
		else if (c <= lsei_pkg::CROSS_NEG_MAX)
			o = lsei_pkg::ORI_CCW;
		else
			o = lsei_pkg::ORI_COL;
		return o;
	endfunction

	// q inside the box spanned by p and r
	function automatic logic between(input lsei_pkg::point_t p, input lsei_pkg::point_t q,
	                                 input lsei_pkg::point_t r);
		lsei_pkg::hcoord_t xlo, xhi, ylo, yhi;
		xlo = ($signed(p.x) < $signed(r.x)) ? p.x : r.x;
		xhi = ($signed(p.x) < $signed(r.x)) ? r.x : p.x;
		ylo = ($signed(p.y) < $signed(r.y)) ? p.y : r.y;
		yhi = ($signed(p.y) < $signed(r.y)) ? r.y : p.y;
		return ($signed(q.x) <= $signed(xhi)) && ($signed(q.x) >= $signed(xlo)) &&
		       ($signed(q.y) <= $signed(yhi)) && ($signed(q.y) >= $signed(ylo));
	endfunction

	lsei_pkg::cross_t cr  [NC];
	lsei_pkg::ori_t   ori [NC];
	lsei_pkg::point_t ep  [NK];
	lsei_pkg::point_t eq  [NK];
	lsei_pkg::ori_t   o1  [NK];
	lsei_pkg::ori_t   o2  [NK];
	logic [NK-1:0]    edge_hit;
	logic             hit;
	logic             v_q, hit_q;

	assign ready_o = !v_q || result.ready;

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			cr[i]  = $signed({m1_i[i][lsei_pkg::PROD_W-1], m1_i[i]}) -
			         $signed({m2_i[i][lsei_pkg::PROD_W-1], m2_i[i]});
			ori[i] = orient(cr[i]);
		end
	end

	assign ep[0] = corners_i.a;
	assign eq[0] = corners_i.b;
	assign ep[1] = corners_i.b;
	assign eq[1] = corners_i.c;
	assign ep[2] = corners_i.c;
	assign eq[2] = corners_i.d;
	assign ep[3] = corners_i.d;
	assign eq[3] = corners_i.a;

	assign o1[0] = ori[0];
	assign o2[0] = ori[1];
	assign o1[1] = ori[1];
	assign o2[1] = ori[2];
	assign o1[2] = ori[2];
	assign o2[2] = ori[3];
	assign o1[3] = ori[3];
	assign o2[3] = ori[0];

	always_comb begin
		for (int e = 0; e < NK; e++) begin
			edge_hit[e] = ((o1[e] != o2[e]) && (ori[4+2*e] != ori[5+2*e])) ||
			              ((o1[e] == lsei_pkg::ORI_COL) && between(line.s, ep[e], line.e)) ||
			              ((o2[e] == lsei_pkg::ORI_COL) && between(line.s, eq[e], line.e)) ||
			              ((ori[4+2*e] == lsei_pkg::ORI_COL) && between(ep[e], line.s, eq[e])) ||
			              ((ori[5+2*e] == lsei_pkg::ORI_COL) && between(ep[e], line.e, eq[e]));
		end
		// closing edge d-a exists only on a rectangle
		hit = edge_hit[0] || edge_hit[1] || edge_hit[2] || (edge_hit[3] && corners_i.is_rect);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_o) begin
			v_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			hit_q <= hit;
		end
	end

	assign result.valid        = v_q;
	assign result.crosses_line = hit_q;

endmodule

>>> hdl/line_shape_edge_intersection_top.sv
// Tests each triangle or rectangle shape transaction against the line segment held in the
// four APB registers and returns one crosses_line flag per shape; circle and other kinds
// are consumed and give no result. One shape is accepted every cycle unless the pipeline
// is stalled; an accepted shape passes through input, corner, cross product and result
// registers, and back-pressure on the result channel stalls the pipeline stage by stage.
// Write the line registers only while no shape is in flight.
module line_shape_edge_intersection_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lsei_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lsei_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lsei_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	lsei_shape_if.sink                      shape,
	lsei_result_if.source                   result
);
	lsei_pkg::line_t    line;
	lsei_pkg::corners_t geom_corners, cross_corners;
	lsei_pkg::prod_t    m1 [lsei_pkg::N_CROSS];
	lsei_pkg::prod_t    m2 [lsei_pkg::N_CROSS];
	logic               geom_valid, cross_ready, cross_valid, decide_ready;

	lsei_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.line    (line)
	);

	lsei_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.shape     (shape),
		.ready_i   (cross_ready),
		.valid_o   (geom_valid),
		.corners_o (geom_corners)
	);

	lsei_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_i   (geom_valid),
		.ready_o   (cross_ready),
		.corners_i (geom_corners),
		.line      (line),
		.valid_o   (cross_valid),
		.ready_i   (decide_ready),
		.corners_o (cross_corners),
		.m1_o      (m1),
		.m2_o      (m2)
	);

	lsei_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_i   (cross_valid),
		.ready_o   (decide_ready),
		.corners_i (cross_corners),
		.line      (line),
		.m1_i      (m1),
		.m2_i      (m2),
		.result    (result)
	);

endmodule
